### hdl/slfp_pkg.sv
// package for the sync/length frame parser
// holds protocol constants, parser phase codes and the result record type
// no dependencies
`default_nettype none

package slfp_pkg;

  localparam logic [7:0]  SYNC_FIRST      = 8'hB5;
  localparam logic [7:0]  SYNC_SECOND     = 8'h62;
  localparam logic [7:0]  ACK_CLASS       = 8'h05;
  localparam logic [15:0] ACK_MAX_LEN     = 16'd2;
  localparam logic [15:0] MAX_LEN_RESET   = 16'd256;

  localparam int unsigned OUT_DATA_W      = 96;
  localparam int unsigned OUT_USER_W      = 2;

  // parser phases
  localparam logic [3:0] PH_SYNC1   = 4'd0;
  localparam logic [3:0] PH_SYNC2   = 4'd1;
  localparam logic [3:0] PH_CLASS   = 4'd2;
  localparam logic [3:0] PH_ID      = 4'd3;
  localparam logic [3:0] PH_LEN_LO  = 4'd4;
  localparam logic [3:0] PH_LEN_HI  = 4'd5;
  localparam logic [3:0] PH_PAYLOAD = 4'd6;
  localparam logic [3:0] PH_CK_A    = 4'd7;
  localparam logic [3:0] PH_CK_B    = 4'd8;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_FRAME   = 2'd1;
  localparam logic [1:0] KIND_LEN_ERR = 2'd2;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [7:0]  msg_class;
    logic [7:0]  msg_id;
    logic [15:0] payload_length;
    logic [7:0]  payload_byte;
    logic [15:0] byte_index;
    logic [7:0]  recv_sum_a;
    logic [7:0]  recv_sum_b;
    logic [7:0]  calc_sum_a;
    logic [7:0]  calc_sum_b;
    logic        sums_match;
  } slfp_result_t;

endpackage

`default_nettype wire

### hdl/slfp_in_stage.sv
// input register stage of the frame parser
// holds one received byte until the parser core can take it
// depends on nothing
`default_nettype none

module slfp_in_stage (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  output logic            in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       take,
  output logic            byte_valid,
  output logic [7:0]      byte_data
);

  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] data_r;

  // refill in the same cycle the held byte is consumed
  assign in_tready  = !valid_r || take;
  assign valid_nxt  = (in_tvalid && in_tready) || (valid_r && !take);
  assign byte_valid = valid_r;
  assign byte_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      data_r <= in_tdata;
    end
  end

endmodule

`default_nettype wire

### hdl/slfp_core.sv
// parser core: phase register, header fields, payload counter and fletcher sums
// computes the result record for the byte being consumed
// depends on slfp_pkg
`default_nettype none

module slfp_core (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                step,
  input  wire logic [7:0]          byte_in,
  input  wire logic [15:0]         max_len,
  output logic                     res_valid,
  output slfp_pkg::slfp_result_t   res
);

  import slfp_pkg::*;

  logic [3:0]  phase_r,   phase_nxt;
  logic [7:0]  class_r,   class_nxt;
  logic [7:0]  id_r,      id_nxt;
  logic [15:0] len_r,     len_nxt;
  logic [15:0] count_r,   count_nxt;
  logic [7:0]  sum_a_r,   sum_a_nxt;
  logic [7:0]  sum_b_r,   sum_b_nxt;
  logic [7:0]  ck_a_r,    ck_a_nxt;

  logic [7:0]  add_a;
  logic [7:0]  add_b;
  logic [15:0] full_len;
  logic [15:0] limit;
  logic [15:0] count_inc;

  // running sums restart at the class byte
  always_comb begin
    if (phase_r == PH_CLASS) begin
      add_a = byte_in;
      add_b = byte_in;
    end else begin
      add_a = sum_a_r + byte_in;
      add_b = sum_b_r + add_a;
    end
  end

  assign full_len  = {byte_in, len_r[7:0]};
  assign limit     = (class_r == ACK_CLASS) ? ACK_MAX_LEN : max_len;
  assign count_inc = count_r + 16'd1;

  always_comb begin
    phase_nxt = phase_r;
    class_nxt = class_r;
    id_nxt    = id_r;
    len_nxt   = len_r;
    count_nxt = count_r;
    sum_a_nxt = sum_a_r;
    sum_b_nxt = sum_b_r;
    ck_a_nxt  = ck_a_r;
    res_valid = 1'b0;
    res       = '0;
    res.msg_class      = class_r;
    res.msg_id         = id_r;
    res.payload_length = len_r;

    unique case (phase_r)
      PH_SYNC2: begin
        if (byte_in == SYNC_SECOND) begin
          phase_nxt = PH_CLASS;
        end else if (byte_in != SYNC_FIRST) begin
          phase_nxt = PH_SYNC1;
        end
      end
      PH_CLASS: begin
        class_nxt = byte_in;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = byte_in;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {8'd0, byte_in};
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = full_len;
        sum_a_nxt = add_a;
        sum_b_nxt = add_b;
        count_nxt = '0;
        res.payload_length = full_len;
        if (full_len > limit) begin
          res_valid       = 1'b1;
          res.result_kind = KIND_LEN_ERR;
          phase_nxt       = PH_SYNC1;
        end else if (full_len == '0) begin
          phase_nxt = PH_CK_A;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        sum_a_nxt        = add_a;
        sum_b_nxt        = add_b;
        res_valid        = 1'b1;
        res.result_kind  = KIND_PAYLOAD;
        res.payload_byte = byte_in;
        res.byte_index   = count_r;
        count_nxt        = count_inc;
        if (count_inc == len_r) begin
          phase_nxt = PH_CK_A;
        end
      end
      PH_CK_A: begin
        ck_a_nxt  = byte_in;
        phase_nxt = PH_CK_B;
      end
      PH_CK_B: begin
        res_valid       = 1'b1;
        res.result_kind = KIND_FRAME;
        res.recv_sum_a  = ck_a_r;
        res.recv_sum_b  = byte_in;
        res.calc_sum_a  = sum_a_r;
        res.calc_sum_b  = sum_b_r;
        res.sums_match  = (ck_a_r == sum_a_r) && (byte_in == sum_b_r);
        phase_nxt       = PH_SYNC1;
      end
      default: begin
        // hunt, also taken by unused phase codes
        phase_nxt = (byte_in == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_SYNC1;
      class_r <= '0;
      id_r    <= '0;
      len_r   <= '0;
      count_r <= '0;
      sum_a_r <= '0;
      sum_b_r <= '0;
      ck_a_r  <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      class_r <= class_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      count_r <= count_nxt;
      sum_a_r <= sum_a_nxt;
      sum_b_r <= sum_b_nxt;
      ck_a_r  <= ck_a_nxt;
    end
  end

endmodule

`default_nettype wire

### hdl/sync_length_frame_parser_top.sv
// sync/length frame parser top level: one byte in, at most one result out per byte.
// a byte is held in the input register; its result is held in the output register.
// throughput: one byte per cycle while out_tready is high; the input
// register, parser core and output register each advance once a cycle.
// reset (rst_n low, synchronous) returns to the sync hunt, empties both
// registers and sets max_payload_len to 256.
`default_nettype none

module sync_length_frame_parser_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_wr_en,
  input  wire logic [15:0]                   cfg_wr_data,  // max_payload_len
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [7:0]                    in_tdata,     // data_byte
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  // msg_class, msg_id, payload_length, payload_byte, byte_index, recv_sum_a,
  // recv_sum_b, calc_sum_a, calc_sum_b, sums_match, zero fill
  output logic [slfp_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic [slfp_pkg::OUT_USER_W-1:0]    out_tuser     // result_kind
);

  import slfp_pkg::*;

  logic          byte_valid;
  logic [7:0]    byte_data;
  logic          out_free;
  logic          step;
  logic          res_valid;
  slfp_result_t  res;

  logic [15:0]   max_len_r;
  logic          out_valid_r;
  logic          out_valid_nxt;
  slfp_result_t  out_res_r;

  assign out_free = !out_valid_r || out_tready;
  assign step     = byte_valid && out_free;

  slfp_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .take       (step),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  slfp_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .byte_in   (byte_data),
    .max_len   (max_len_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_len_r <= MAX_LEN_RESET;
    end else if (cfg_wr_en) begin
      max_len_r <= cfg_wr_data;
    end
  end

  assign out_valid_nxt = out_free ? (step && res_valid) : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.result_kind;
  assign out_tdata  = {7'd0,
                       out_res_r.sums_match,
                       out_res_r.calc_sum_b,
                       out_res_r.calc_sum_a,
                       out_res_r.recv_sum_b,
                       out_res_r.recv_sum_a,
                       out_res_r.byte_index,
                       out_res_r.payload_byte,
                       out_res_r.payload_length,
                       out_res_r.msg_id,
                       out_res_r.msg_class};

endmodule

`default_nettype wire

### sim/sync_length_frame_parser_top_test.sv
// self-checking testbench for sync_length_frame_parser_top
// drives a byte stream of frames, noise and broken frames, predicts the parser results
// and checks them in order; depends on slfp_pkg and the top level
`timescale 1ns / 1ps

module sync_length_frame_parser_top_test;
  import slfp_pkg::*;

  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_BYTES = 360;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [OUT_USER_W-1:0] out_tuser;

  sync_length_frame_parser_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #2 clk = ~clk;

  // byte stream waiting to be sent and parser results still to arrive
  logic [7:0]   tx_bytes[$];
  slfp_result_t parsed_q[$];
  int           err_count = 0;
  int           bytes_queued = 0;

  // parser mirror
  logic [3:0]  ph;
  logic [7:0]  f_class, f_id, fa, fb, ck_first;
  logic [15:0] f_len, pay_cnt;
  logic [15:0] max_len_cfg = MAX_LEN_RESET;

  // idling controls, set from the stimulus process at falling edges
  int          sender_mode = 0;
  int          sink_mode = 0;
  logic [7:0]  sink_pattern = 8'hFF;
  int          hold_seq = 0;

  task automatic report_error(input string msg);
    $display("ERROR at %0t: %s", $realtime, msg);
    err_count++;
  endtask

  function automatic logic [15:0] len_limit(input logic [7:0] cls);
    return (cls == ACK_CLASS) ? ACK_MAX_LEN : max_len_cfg;
  endfunction

  function automatic slfp_result_t frame_header(input logic [1:0] kind);
    slfp_result_t r;
    r = '0;
    r.result_kind    = kind;
    r.msg_class      = f_class;
    r.msg_id         = f_id;
    r.payload_length = f_len;
    return r;
  endfunction

  task automatic parse_byte(input logic [7:0] b);
    slfp_result_t r;
    case (ph)
      PH_SYNC2: begin
        if (b == SYNC_SECOND) ph = PH_CLASS;
        else if (b != SYNC_FIRST) ph = PH_SYNC1;
      end
      PH_CLASS: begin
        f_class = b;
        fa = b;
        fb = b;
        ph = PH_ID;
      end
      PH_ID: begin
        f_id = b;
        fa = fa + b;
        fb = fb + fa;
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        f_len = {8'h00, b};
        fa = fa + b;
        fb = fb + fa;
        ph = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        f_len = {b, f_len[7:0]};
        fa = fa + b;
        fb = fb + fa;
        pay_cnt = '0;
        if (f_len > len_limit(f_class)) begin
          parsed_q.push_back(frame_header(KIND_LEN_ERR));
          ph = PH_SYNC1;
        end else begin
          ph = (f_len == 0) ? PH_CK_A : PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        fa = fa + b;
        fb = fb + fa;
        r = frame_header(KIND_PAYLOAD);
        r.payload_byte = b;
        r.byte_index = pay_cnt;
        parsed_q.push_back(r);
        pay_cnt = pay_cnt + 16'd1;
        if (pay_cnt == f_len) ph = PH_CK_A;
      end
      PH_CK_A: begin
        ck_first = b;
        ph = PH_CK_B;
      end
      PH_CK_B: begin
        r = frame_header(KIND_FRAME);
        r.recv_sum_a = ck_first;
        r.recv_sum_b = b;
        r.calc_sum_a = fa;
        r.calc_sum_b = fb;
        r.sums_match = (ck_first == fa) && (b == fb);
        parsed_q.push_back(r);
        ph = PH_SYNC1;
      end
      default: ph = (b == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
    endcase
  endtask

  // driver: bursts of random length, with random gaps in between when sender_mode is nonzero
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
      burst_left <= 0;
      gap_left <= 0;
      ph = PH_SYNC1;
      f_class = '0;
      f_id = '0;
      f_len = '0;
      pay_cnt = '0;
      fa = '0;
      fb = '0;
      ck_first = '0;
      max_len_cfg = MAX_LEN_RESET;
    end else begin
      if (in_tvalid && in_tready) parse_byte(in_tdata);
      if (!in_tvalid || in_tready) begin
        if (gap_left != 0) begin
          in_tvalid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (tx_bytes.size() != 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= tx_bytes.pop_front();
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 24);
            gap_left <= (sender_mode != 0) ? $urandom_range(0, 6) : 0;
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: always ready, random, or a rotating pattern; long hold-off on request
  int       hold_left = 0;
  int       hold_seen = 0;
  logic [2:0] pat_pos = '0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      hold_seen <= 0;
      pat_pos <= '0;
    end else if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      case (sink_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          out_tready <= sink_pattern[pat_pos];
          pat_pos <= pat_pos + 3'd1;
        end
      endcase
    end
  end

  task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  // monitor
  always @(posedge clk) begin
    slfp_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.result_kind    = out_tuser;
      got.msg_class      = out_tdata[7:0];
      got.msg_id         = out_tdata[15:8];
      got.payload_length = out_tdata[31:16];
      got.payload_byte   = out_tdata[39:32];
      got.byte_index     = out_tdata[55:40];
      got.recv_sum_a     = out_tdata[63:56];
      got.recv_sum_b     = out_tdata[71:64];
      got.calc_sum_a     = out_tdata[79:72];
      got.calc_sum_b     = out_tdata[87:80];
      got.sums_match     = out_tdata[88];
      if (parsed_q.size() == 0) begin
        report_error($sformatf("unexpected result, kind %0d", got.result_kind));
      end else begin
        want = parsed_q.pop_front();
        check_field("result_kind", 16'(got.result_kind), 16'(want.result_kind));
        check_field("msg_class", 16'(got.msg_class), 16'(want.msg_class));
        check_field("msg_id", 16'(got.msg_id), 16'(want.msg_id));
        check_field("payload_length", got.payload_length, want.payload_length);
        check_field("payload_byte", 16'(got.payload_byte), 16'(want.payload_byte));
        check_field("byte_index", got.byte_index, want.byte_index);
        check_field("recv_sum_a", 16'(got.recv_sum_a), 16'(want.recv_sum_a));
        check_field("recv_sum_b", 16'(got.recv_sum_b), 16'(want.recv_sum_b));
        check_field("calc_sum_a", 16'(got.calc_sum_a), 16'(want.calc_sum_a));
        check_field("calc_sum_b", 16'(got.calc_sum_b), 16'(want.calc_sum_b));
        check_field("sums_match", 16'(got.sums_match), 16'(want.sums_match));
      end
    end
  end

  // watchdog on cycles without any handshake or configuration write
  int stall_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    tx_bytes.push_back(b);
    bytes_queued++;
  endtask

  // flaw: 0 clean, 1 corrupted checksum, 2 cut short inside the payload
  task automatic push_frame(input logic [7:0] cls, input logic [7:0] id, input int len,
                            input int flaw, input bit dup_sync);
    logic [7:0]  sa, sb, b;
    logic [15:0] lv;
    logic [7:0]  hdr[4];
    int          cut;
    lv = len[15:0];
    hdr = '{cls, id, lv[7:0], lv[15:8]};
    sa = '0;
    sb = '0;
    send_byte(SYNC_FIRST);
    if (dup_sync) send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    foreach (hdr[k]) begin
      send_byte(hdr[k]);
      sa = sa + hdr[k];
      sb = sb + sa;
    end
    if (len > int'(len_limit(cls))) return;
    cut = (flaw == 2 && len > 0) ? $urandom_range(0, len - 1) : len;
    for (int k = 0; k < cut; k++) begin
      b = 8'($urandom);
      send_byte(b);
      sa = sa + b;
      sb = sb + sa;
    end
    if (cut != len) return;
    if (flaw == 1) begin
      case ($urandom_range(0, 2))
        0: sa = sa ^ (8'h01 << $urandom_range(0, 7));
        1: sb = sb ^ (8'h01 << $urandom_range(0, 7));
        default: begin
          sa = ~sa;
          sb = sb + 8'd1;
        end
      endcase
    end
    send_byte(sa);
    send_byte(sb);
  endtask

  function automatic int pick_len(input logic [7:0] cls);
    int lim, r, n;
    lim = int'(len_limit(cls));
    r = $urandom_range(0, 99);
    if (r < 70) n = $urandom_range(0, 12);
    else if (r < 85) n = (lim > 300) ? $urandom_range(0, 40) : lim - 1 + $urandom_range(0, 2);
    else n = (lim < 65535) ? $urandom_range(65535, lim + 1) : $urandom_range(0, 40);
    if (n < 0) n = 0;
    // keep accepted payloads short so the run stays small
    if (n <= lim && n > 300) n = n % 40;
    return n;
  endfunction

  task automatic wait_drained();
    while (tx_bytes.size() != 0 || in_tvalid || parsed_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_max_len(input logic [15:0] v);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    max_len_cfg = v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic random_traffic(input int n_bytes);
    int stop_at, r;
    logic [7:0] cls;
    stop_at = bytes_queued + n_bytes;
    while (bytes_queued < stop_at) begin
      r = $urandom_range(0, 99);
      cls = ($urandom_range(0, 3) == 0) ? ACK_CLASS : 8'($urandom);
      if (r < 75) begin
        push_frame(cls, 8'($urandom), pick_len(cls), 0, $urandom_range(0, 7) == 0);
      end else if (r < 85) begin
        push_frame(cls, 8'($urandom), pick_len(cls), 1, $urandom_range(0, 7) == 0);
      end else if (r < 90) begin
        push_frame(cls, 8'($urandom), pick_len(cls), 2, 1'b0);
      end else begin
        // noise, sometimes a lone or doubled first sync byte
        repeat ($urandom_range(1, 6)) begin
          if ($urandom_range(0, 3) == 0) send_byte(SYNC_FIRST);
          else send_byte(8'($urandom));
        end
      end
    end
  endtask

  logic [15:0] phase_max[5];

  initial begin
    phase_max = '{16'd0, 16'hFFFF, 16'd1, 16'd256, 16'd0};
    phase_max[2] = 16'($urandom_range(1, 40));
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: doubled sync on an acknowledge frame, zero length, longest length,
    // a first sync byte followed by a non-sync byte
    push_frame(ACK_CLASS, 8'h01, 2, 0, 1'b1);
    push_frame(8'h01, 8'h02, 0, 0, 1'b0);
    push_frame(8'hFF, 8'hFF, 65535, 0, 1'b0);
    send_byte(SYNC_FIRST);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_drained();

    foreach (phase_max[i]) begin
      write_max_len(phase_max[i]);
      sender_mode = i % 2;
      sink_mode = (i + 1) % 3;
      sink_pattern = 8'($urandom) | 8'h01;
      random_traffic(PHASE_BYTES);
      if (i == 2) hold_seq++;
      wait_drained();
    end

    repeat (10) @(negedge clk);
    if (parsed_q.size() != 0)
      report_error($sformatf("%0d results never arrived", parsed_q.size()));
    if (err_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
